[rtl/humidity_temp_frame_checker_macros.svh]
// Assertion macros for the humidity and temperature frame checker.
// Used by the RTL files that assert; clock i_clk and reset i_rst_n are implied.
`ifndef HUMIDITY_TEMP_FRAME_CHECKER_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_CHECKER_MACROS_SVH

`ifndef SYNTH

// Condition a implies condition b in the same cycle.
`define HTFC_ASSERT_IMPL(lbl, a, b, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error(msg);

// Condition a implies condition b in the next cycle.
`define HTFC_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error(msg);

`else

`define HTFC_ASSERT_IMPL(lbl, a, b, msg)
`define HTFC_ASSERT_NEXT(lbl, a, b, msg)

`endif

`endif

[rtl/htfc_pkg.sv]
// Shared types, constants and the CRC-8 step for the frame checker.
// No dependencies; imported by htfc_frame and humidity_temp_frame_checker.
package htfc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Byte positions within the six-byte frame.
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // Conversion constants, hundredths of a unit.
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;

    localparam logic signed [14:0] TEMP_MIN_RESET = -15'sd2000;
    localparam logic signed [14:0] TEMP_MAX_RESET = 15'sd12500;

    // Configuration register indexes.
    localparam logic CFG_TEMP_MIN = 1'b0;
    localparam logic CFG_TEMP_MAX = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CRC_ERR = 2'd1,
        STATUS_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        crc_ok;
    } t_frame;

    // One byte of CRC-8, MSB first, no final xor.
    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (r[7]) begin
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

[rtl/humidity_temp_frame_checker.sv]
// Top level of the humidity and temperature frame checker.
// Depends on htfc_pkg, htfc_frame and humidity_temp_frame_checker_macros.svh.

// The block takes one byte of the six-byte sensor frame per cycle while
// o_in_ready is high, with no gaps needed between bytes or frames; the
// combinational CRC-8 byte step in the frame tracker sets that figure. The
// result for a frame (converted temperature and humidity, and a status) is
// registered through a four-register pipeline after the sixth byte is taken:
// raw words, products, quotients and range check. The user writes limits through
// the configuration port while the block is idle; the block does not enforce it.
`include "humidity_temp_frame_checker_macros.svh"

module humidity_temp_frame_checker
    import htfc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [14:0] o_temperature_centi,
    output logic [13:0]        o_humidity_centi,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [14:0]        i_cfg_data
);

    logic signed [14:0] r_temp_min;
    logic signed [14:0] r_temp_max;

    logic   in_accept;
    logic   frame_done;
    t_frame frame;

    logic en_p, en_m, en_d, en_o;

    // Stage registers.
    logic               r_p_valid;
    t_frame             r_p_frame;
    logic               r_m_valid;
    logic [30:0]        r_m_temp_prod;
    logic [29:0]        r_m_hum_prod;
    logic               r_m_crc_ok;
    logic               r_d_valid;
    logic signed [14:0] r_d_temp;
    logic [13:0]        r_d_hum;
    logic               r_d_crc_ok;
    logic               r_o_valid;
    logic signed [14:0] r_o_temp;
    logic [13:0]        r_o_hum;
    t_status            r_o_status;

    logic [31:0] temp_sum;
    logic [31:0] hum_sum;
    logic [15:0] temp_q;
    logic [15:0] hum_q;
    logic [15:0] temp_shift;
    t_status     status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_min <= TEMP_MIN_RESET;
            r_temp_max <= TEMP_MAX_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TEMP_MIN) begin
                r_temp_min <= $signed(i_cfg_data);
            end else begin
                r_temp_max <= $signed(i_cfg_data);
            end
        end
    end

    // Each stage advances when the stage after it is empty or moving.
    assign en_o = !r_o_valid || i_out_ready;
    assign en_d = !r_d_valid || en_o;
    assign en_m = !r_m_valid || en_d;
    assign en_p = !r_p_valid || en_m;

    assign o_in_ready = en_p;
    assign in_accept  = i_in_valid && en_p;

    htfc_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_done        (frame_done),
        .o_frame       (frame)
    );

    // Division by 65535: q = (x + (x >> 16) + 1) >> 16 is exact while q fits 16 bits.
    always_comb begin
        temp_sum   = {1'b0, r_m_temp_prod} + {17'd0, r_m_temp_prod[30:16]} + 32'd1;
        hum_sum    = {2'b0, r_m_hum_prod} + {18'd0, r_m_hum_prod[29:16]} + 32'd1;
        temp_q     = temp_sum[31:16];
        hum_q      = hum_sum[31:16];
        temp_shift = temp_q - TEMP_OFFSET;
    end

    always_comb begin
        if (!r_d_crc_ok) begin
            status = STATUS_CRC_ERR;
        end else if ((r_d_temp < r_temp_min) || (r_d_temp > r_temp_max)) begin
            status = STATUS_RANGE;
        end else begin
            status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_p) r_p_valid <= frame_done;
            if (en_m) r_m_valid <= r_p_valid;
            if (en_d) r_d_valid <= r_m_valid;
            if (en_o) r_o_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p) begin
            r_p_frame <= frame;
        end
        if (en_m) begin
            r_m_temp_prod <= {15'd0, r_p_frame.temp_raw} * {16'd0, TEMP_SPAN};
            r_m_hum_prod  <= {14'd0, r_p_frame.hum_raw} * {16'd0, HUM_SPAN};
            r_m_crc_ok    <= r_p_frame.crc_ok;
        end
        if (en_d) begin
            r_d_temp   <= $signed(temp_shift[14:0]);
            r_d_hum    <= hum_q[13:0];
            r_d_crc_ok <= r_m_crc_ok;
        end
        if (en_o) begin
            r_o_temp   <= r_d_temp;
            r_o_hum    <= r_d_hum;
            r_o_status <= status;
        end
    end

    assign o_out_valid         = r_o_valid;
    assign o_temperature_centi = r_o_temp;
    assign o_humidity_centi    = r_o_hum;
    assign o_status            = r_o_status;

    `HTFC_ASSERT_IMPL(a_ok_in_range, o_out_valid && (o_status == STATUS_OK),
        (o_temperature_centi >= r_temp_min) && (o_temperature_centi <= r_temp_max),
        "ok word outside limits")
    `HTFC_ASSERT_IMPL(a_hum_bound, o_out_valid, o_humidity_centi <= 14'd10000,
        "humidity above full scale")
    `HTFC_ASSERT_IMPL(a_temp_bound, o_out_valid,
        (o_temperature_centi >= -15'sd4500) && (o_temperature_centi <= 15'sd13000),
        "temperature beyond scale")
    `HTFC_ASSERT_NEXT(a_d_hold, r_d_valid && !en_d, r_d_valid && $stable(r_d_temp),
        "quotient stage lost a word")

endmodule

[rtl/htfc_frame.sv]
// Frame tracker: byte position, running CRC-8 and capture of the two raw words.
// Depends on htfc_pkg; emits one t_frame word when the sixth byte is taken.
module htfc_frame
    import htfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    output logic       o_done,
    output t_frame     o_frame
);

    logic [2:0] r_idx, n_idx;
    logic [7:0] r_crc, n_crc;
    logic       r_t_ok, n_t_ok;
    logic [7:0] r_word [0:3];

    logic [2:0] idx;
    logic [7:0] crc_in;
    logic [7:0] crc_next;
    logic       wr_en;
    logic [1:0] wr_addr;
    logic       done;

    always_comb begin
        // A frame mark or a position past the end restarts at the first byte.
        if (i_frame_start || (r_idx > POS_H_CRC)) begin
            idx    = POS_T_HI;
            crc_in = CRC_INIT;
        end else begin
            idx    = r_idx;
            crc_in = r_crc;
        end
        crc_next = crc8_byte(crc_in, i_rx_byte);

        n_idx   = r_idx;
        n_crc   = r_crc;
        n_t_ok  = r_t_ok;
        wr_en   = 1'b0;
        wr_addr = 2'd0;
        done    = 1'b0;

        if (i_accept) begin
            case (idx)
                POS_T_HI, POS_T_LO: begin
                    wr_en   = 1'b1;
                    wr_addr = idx[1:0];
                    n_crc   = crc_next;
                    n_idx   = idx + 3'd1;
                end
                POS_T_CRC: begin
                    n_t_ok = (crc_in == i_rx_byte);
                    n_crc  = CRC_INIT;
                    n_idx  = POS_H_HI;
                end
                POS_H_HI, POS_H_LO: begin
                    wr_en   = 1'b1;
                    wr_addr = 2'(idx - 3'd1);
                    n_crc   = crc_next;
                    n_idx   = idx + 3'd1;
                end
                default: begin
                    done  = 1'b1;
                    n_crc = CRC_INIT;
                    n_idx = POS_T_HI;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= POS_T_HI;
            r_crc  <= CRC_INIT;
            r_t_ok <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_crc  <= n_crc;
            r_t_ok <= n_t_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_word[wr_addr] <= i_rx_byte;
        end
    end

    assign o_done           = done;
    assign o_frame.temp_raw = {r_word[0], r_word[1]};
    assign o_frame.hum_raw  = {r_word[2], r_word[3]};
    assign o_frame.crc_ok   = r_t_ok && (crc_in == i_rx_byte);

endmodule
